### design/sdepq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the sorted double-ended priority queue.
// No dependencies; imported by the cell and the top level.
package sdepq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;     // width of the entry_count field
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 32;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 104;   // 101 bits of fields, padded to bytes

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MIN = 2'd1,
        CMD_DEL_MAX = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation actually applied to the chain (after full/empty checks)
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DEL_MIN,
        OP_DEL_MAX
    } op_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    // What a cell shows to its neighbors and to the top level
    typedef struct packed {
        logic   valid;
        logic   take;       // cell is at or beyond the insert position
        entry_t ent;
        logic   valid_nx;
        entry_t ent_nx;
    } cell_out_t;

endpackage : sdepq_pkg
`default_nettype wire

### design/sorted_double_ended_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted double-ended priority queue: a chain of cells ordered by priority,
// with an output register. Depends on sdepq_pkg and sdepq_cell.
//
// Usage:
//   Input stream s_*: s_tuser carries the command (insert, delete minimum,
//   delete maximum, query); s_tdata carries data and signed Q16.16 priority.
//   Output stream m_*: one result item per input item; m_tuser carries the
//   status, m_tdata the removed data, count and data at both ends.
//   Every cell compares its priority with the incoming one in parallel and
//   takes its own, its neighbor's or the new entry in the same cycle, so an
//   item is applied as soon as it is accepted. The result is registered: it
//   appears in the cycle after acceptance; one item per cycle while m_tready is high.
//   The minimum-end and maximum-end data are selected from the chain's next
//   state, the maximum end through a one-hot OR over the cells.
//   Reset clears all valid bits and the count; the queue starts empty.
//   If the receiver stalls, the result is held and s_tready drops until the
//   output register is emptied; no item is lost or repeated.
module sorted_double_ended_priority_queue
    import sdepq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // data_in[31:0], priority_in[63:32]
    input  wire logic [1:0]       s_tuser,   // cmd[1:0]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // removed_data[31:0], entry_count[36:32],
                                             // min_data[68:37], max_data[100:69], zero pad
    output logic [1:0]            m_tuser    // status[1:0]
);

    cell_out_t          cq    [CAPACITY];
    cell_out_t          lft   [CAPACITY];
    cell_out_t          rgt   [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] therm_chk;

    op_t                op;
    entry_t             new_ent;
    cmd_t               cmd;
    logic               s_accept;
    logic               full;
    logic               empty;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    status_t            status_c;
    logic [DATA_W-1:0]  removed_c;
    logic [DATA_W-1:0]  min_c;
    logic [DATA_W-1:0]  max_c;
    logic [DATA_W-1:0]  last_cur_data;

    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    status_t            status_reg;
    logic [DATA_W-1:0]  removed_reg;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic [DATA_W-1:0]  min_reg;
    logic [DATA_W-1:0]  max_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign new_ent.data = s_tdata[DATA_W-1:0];
    assign new_ent.prio = s_tdata[DATA_W +: PRIO_W];
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        op         = OP_HOLD;
        status_c   = ST_OK;
        count_next = count_reg;
        if (s_accept)
        begin
            case (cmd)
                CMD_INSERT:
                begin
                    if (full)
                        status_c = ST_FULL;
                    else
                    begin
                        op         = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_DEL_MIN:
                begin
                    if (empty)
                        status_c = ST_EMPTY;
                    else
                    begin
                        op         = OP_DEL_MIN;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_DEL_MAX:
                begin
                    if (empty)
                        status_c = ST_EMPTY;
                    else
                    begin
                        op         = OP_DEL_MAX;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    op = OP_HOLD;
                end
            endcase
        end
    end

    // Neighbor wiring; the minimum end sees a valid, non-taking left edge
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                lft[i]       = '0;
                lft[i].valid = 1'b1;
            end
            else
                lft[i] = cq[i-1];
            if (i == CAPACITY - 1)
                rgt[i] = '0;
            else
                rgt[i] = cq[i+1];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        sdepq_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .op      (op),
            .new_ent (new_ent),
            .left    (lft[g]),
            .right   (rgt[g]),
            .q       (cq[g])
        );
    end

    // Ends of the chain: current last cell for delete-max, next state for reporting
    always_comb
    begin
        last_cur_data = '0;
        max_c         = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_vec[i] = cq[i].valid;
            if (cq[i].valid && !rgt[i].valid)
                last_cur_data = last_cur_data | cq[i].ent.data;
            if (cq[i].valid_nx && !rgt[i].valid_nx)
                max_c = max_c | cq[i].ent_nx.data;
        end
        min_c = cq[0].valid_nx ? cq[0].ent_nx.data : '0;
        case (op)
            OP_DEL_MIN: removed_c = cq[0].ent.data;
            OP_DEL_MAX: removed_c = last_cur_data;
            default:    removed_c = '0;
        endcase
    end

    assign therm_chk     = valid_vec & (valid_vec + 1'b1);
    assign m_tvalid_next = s_accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            status_reg  <= status_c;
            removed_reg <= removed_c;
            cnt_out_reg <= COUNT_W'(count_next);
            min_reg     <= min_c;
            max_reg     <= max_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, max_reg, min_reg, cnt_out_reg, removed_reg};

    // Count register tracks the number of valid cells
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count differs from valid cells");

    // Valid cells form a contiguous run from the minimum end
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        therm_chk == '0)
        else $error("gap in valid cells");

    // Insert into a full queue reports full status
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && cmd == CMD_INSERT && full) |=> (m_tuser == ST_FULL))
        else $error("full insert not reported");

    // Delete from an empty queue leaves it empty
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (cmd == CMD_DEL_MIN || cmd == CMD_DEL_MAX) && empty)
        |=> (count_reg == '0 && m_tuser == ST_EMPTY))
        else $error("delete on empty queue changed state");

endmodule : sorted_double_ended_priority_queue
`default_nettype wire

### design/sdepq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One storage cell of the sorted chain: holds an entry and a valid bit.
// Depends on sdepq_pkg.
module sdepq_cell
    import sdepq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire op_t       op,
    input  wire entry_t    new_ent,
    input  wire cell_out_t left,     // toward the minimum end
    input  wire cell_out_t right,    // toward the maximum end
    output cell_out_t      q
);

    logic   valid_reg;
    logic   valid_next;
    entry_t ent_reg;
    entry_t ent_next;
    logic   take;

    // Chain is sorted, so take is a thermometer along the cells
    assign take = !valid_reg || ($signed(ent_reg.prio) >= $signed(new_ent.prio));

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        case (op)
            OP_INSERT:
            begin
                valid_next = valid_reg | left.valid;
                if (take && !left.take)
                    ent_next = new_ent;
                else if (take)
                    ent_next = left.ent;
            end
            OP_DEL_MIN:
            begin
                valid_next = right.valid;
                ent_next   = right.ent;
            end
            OP_DEL_MAX:
            begin
                valid_next = valid_reg & right.valid;
            end
            default:
            begin
                valid_next = valid_reg;
                ent_next   = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_comb
    begin
        q.valid    = valid_reg;
        q.take     = take;
        q.ent      = ent_reg;
        q.valid_nx = valid_next;
        q.ent_nx   = ent_next;
    end

endmodule : sdepq_cell
`default_nettype wire
